@@ hw/rtl/cbp_pkg.sv @@
// ----------------------------------------------------------------------------
// cbp_pkg
// Shared constants and types of the census transform block: window geometry,
// field widths and the position record handed from the scan counters.
// ----------------------------------------------------------------------------
package cbp_pkg;

   // Window geometry
   localparam int RADIUS     = 1;
   localparam int MAX_WIDTH  = 1024;
   localparam int PIXEL_BITS = 8;

   localparam int SPAN     = 2 * RADIUS + 1;
   localparam int LINES    = 2 * RADIUS;
   localparam int WIN_SIZE = SPAN * SPAN;
   localparam int CENTER   = RADIUS * SPAN + RADIUS;

   // Field widths of the channels
   localparam int IN_PIX_W = 8;
   localparam int WIDTH_W  = 11;
   localparam int COL_W    = 10;
   localparam int ROW_W    = 12;
   localparam int CENSUS_W = 8;

   // Line memory address and counter compare widths
   localparam int IDX_W = $clog2(MAX_WIDTH);
   localparam int CMP_W = ((IDX_W > WIDTH_W) ? IDX_W : WIDTH_W) + 1;

   // Reset value of the width register
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(640);

   typedef logic [PIXEL_BITS-1:0] pixel_type;
   typedef logic [LINES-1:0][PIXEL_BITS-1:0] line_word_type;

   // Position of one request in the frame, as seen by the scan counters
   typedef struct packed {
      logic [IDX_W-1:0] addr;
      logic             emit;
      logic [COL_W-1:0] center_col;
      logic [ROW_W-1:0] center_row;
   } pos_type;

endpackage

@@ hw/rtl/cbp_req_if.sv @@
// ----------------------------------------------------------------------------
// cbp_req_if
// Pixel request channel: valid/ready handshake with pixel and frame flag.
// ----------------------------------------------------------------------------
interface cbp_req_if;
   logic                         valid;
   logic                         ready;
   logic [cbp_pkg::IN_PIX_W-1:0] pixel_value;
   logic                         frame_start;

   modport source (output valid, output pixel_value, output frame_start, input ready);
   modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

@@ hw/rtl/cbp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// cbp_rsp_if
// Census result channel: valid/ready handshake with census word and center.
// ----------------------------------------------------------------------------
interface cbp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [cbp_pkg::CENSUS_W-1:0] census_bits;
   logic [cbp_pkg::COL_W-1:0]    center_col;
   logic [cbp_pkg::ROW_W-1:0]    center_row;

   modport source (output valid, output census_bits, output center_col,
                   output center_row, input ready);
   modport sink   (input valid, input census_bits, input center_col,
                   input center_row, output ready);
endinterface

@@ hw/rtl/cbp_csr_if.sv @@
// ----------------------------------------------------------------------------
// cbp_csr_if
// Configuration write channel: valid/ready handshake carrying the row width.
// ----------------------------------------------------------------------------
interface cbp_csr_if;
   logic                        valid;
   logic                        ready;
   logic [cbp_pkg::WIDTH_W-1:0] image_width;

   modport source (output valid, output image_width, input ready);
   modport sink   (input valid, input image_width, output ready);
endinterface

@@ hw/rtl/census_bit_planes.sv @@
// ----------------------------------------------------------------------------
// census_bit_planes
// Streaming 3x3 census transform over 8-bit raster pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per clock on the request channel while the result channel
// keeps ready high. An accepted pixel waits in the input stage, where the
// line memory, read at acceptance, returns registered data and the window
// shift and census compare complete; the result then loads into the output
// register unless an earlier result still waits there. The result register
// and the input stage are separate, so one new request is taken while a
// result waits. Each result carries the census word of a center pixel whose
// whole window lies inside the frame, with its column and row; border pixels
// give none. The row width is to be written on the configuration channel
// only while the block is idle; the block itself does not enforce this. The
// width is clamped to the window span and the line memory depth.
module census_bit_planes (
   input  logic       clock,
   input  logic       reset,
   cbp_req_if.sink    req_chan,
   cbp_rsp_if.source  rsp_chan,
   cbp_csr_if.sink    csr_chan
);

   cbp_pkg::pos_type pos;
   logic             accept;

   // Width register and raster counters
   cbp_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .csr_chan    (csr_chan),
      .frame_start (req_chan.frame_start),
      .accept      (accept),
      .pos         (pos)
   );

   // Line memory, window and census result
   cbp_census u_census (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .pos      (pos),
      .accept   (accept)
   );

endmodule

@@ hw/rtl/cbp_ram.sv @@
// ----------------------------------------------------------------------------
// cbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/cbp_scan.sv @@
// ----------------------------------------------------------------------------
// cbp_scan
// Width register and raster counters. Gives the line memory address, the
// center position and the emit flag for the request now offered.
// ----------------------------------------------------------------------------
module cbp_scan (
   input  logic             clock,
   input  logic             reset,
   cbp_csr_if.sink          csr_chan,
   input  logic             frame_start,
   input  logic             accept,
   output cbp_pkg::pos_type pos
);

   logic [cbp_pkg::WIDTH_W-1:0] image_width_ff, image_width_in;
   logic [cbp_pkg::IDX_W-1:0]   column_ff, column_in;
   logic [cbp_pkg::ROW_W-1:0]   row_ff, row_in;

   logic [cbp_pkg::CMP_W-1:0]   eff_width;
   logic [cbp_pkg::CMP_W-1:0]   column_next;
   logic [cbp_pkg::IDX_W-1:0]   col_cur;
   logic [cbp_pkg::ROW_W-1:0]   row_cur;
   logic                        row_wrap;

   // Take every configuration write at once
   assign csr_chan.ready = 1'b1;

   always_comb begin
      image_width_in = image_width_ff;
      if (csr_chan.valid) begin
         image_width_in = csr_chan.image_width;
      end
   end

   // Clamp the width to the window span and the line memory depth
   always_comb begin
      eff_width = cbp_pkg::CMP_W'(image_width_ff);
      if (eff_width < cbp_pkg::CMP_W'(cbp_pkg::SPAN)) begin
         eff_width = cbp_pkg::CMP_W'(cbp_pkg::SPAN);
      end else if (eff_width > cbp_pkg::CMP_W'(cbp_pkg::MAX_WIDTH)) begin
         eff_width = cbp_pkg::CMP_W'(cbp_pkg::MAX_WIDTH);
      end
   end

   // Position of the offered pixel; a frame start puts it at the origin
   always_comb begin
      col_cur     = frame_start ? '0 : column_ff;
      row_cur     = frame_start ? '0 : row_ff;
      column_next = cbp_pkg::CMP_W'(col_cur) + cbp_pkg::CMP_W'(1);
      row_wrap    = (column_next >= eff_width);
   end

   // Advance the counters on each accepted request, saturating the row
   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (accept) begin
         if (row_wrap) begin
            column_in = '0;
            row_in    = (row_cur == '1) ? row_cur : row_cur + cbp_pkg::ROW_W'(1);
         end else begin
            column_in = cbp_pkg::IDX_W'(column_next);
            row_in    = row_cur;
         end
      end
   end

   // Center of the window that ends at this pixel
   always_comb begin
      pos.addr       = col_cur;
      pos.emit       = (col_cur >= cbp_pkg::IDX_W'(cbp_pkg::LINES)) &&
                       (row_cur >= cbp_pkg::ROW_W'(cbp_pkg::LINES));
      pos.center_col = cbp_pkg::COL_W'(col_cur - cbp_pkg::IDX_W'(cbp_pkg::RADIUS));
      pos.center_row = row_cur - cbp_pkg::ROW_W'(cbp_pkg::RADIUS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= cbp_pkg::WIDTH_RESET;
         column_ff      <= '0;
         row_ff         <= '0;
      end else begin
         image_width_ff <= image_width_in;
         column_ff      <= column_in;
         row_ff         <= row_in;
      end
   end

endmodule

@@ hw/rtl/cbp_census.sv @@
// ----------------------------------------------------------------------------
// cbp_census
// Input stage, line memory, window shift register, census compare and the
// result register. The line memory is read when a request is accepted and
// written back as the input stage advances, with a bypass for back-to-back
// requests at the same column.
// ----------------------------------------------------------------------------
module cbp_census (
   input  logic             clock,
   input  logic             reset,
   cbp_req_if.sink          req_chan,
   cbp_rsp_if.source        rsp_chan,
   input  cbp_pkg::pos_type pos,
   output logic             accept
);

   // Input stage
   logic                   s1_valid_ff, s1_valid_in;
   cbp_pkg::pos_type       s1_pos_ff;
   cbp_pkg::pixel_type     s1_pixel_ff;

   // Bypass of the line word written in the cycle of the read
   logic                   fwd_hit_ff, fwd_hit_in;
   cbp_pkg::line_word_type fwd_data_ff;

   // Window and result register
   cbp_pkg::pixel_type     window_ff [cbp_pkg::WIN_SIZE];
   cbp_pkg::pixel_type     win_next  [cbp_pkg::WIN_SIZE];
   logic                   out_valid_ff, out_valid_in;
   logic [cbp_pkg::CENSUS_W-1:0] out_bits_ff;
   logic [cbp_pkg::COL_W-1:0]    out_col_ff;
   logic [cbp_pkg::ROW_W-1:0]    out_row_ff;

   logic                   advance;
   logic [cbp_pkg::LINES*cbp_pkg::PIXEL_BITS-1:0] rd_data;
   cbp_pkg::line_word_type line_word;
   cbp_pkg::line_word_type wr_word;
   cbp_pkg::pixel_type     column [cbp_pkg::SPAN];
   cbp_pkg::pixel_type     center;
   logic [cbp_pkg::WIN_SIZE-2:0] neighbor_le;

   // Handshake: the stage moves on whenever the result register frees up
   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      fwd_hit_in = fwd_hit_ff;
      if (accept) begin
         fwd_hit_in = advance && (s1_pos_ff.addr == pos.addr);
      end else if (advance) begin
         fwd_hit_in = 1'b0;
      end
   end

   // Line memory: one entry holds the stored rows of one column
   cbp_ram #(
      .WIDTH (cbp_pkg::LINES * cbp_pkg::PIXEL_BITS),
      .DEPTH (cbp_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (s1_pos_ff.addr),
      .wr_data (wr_word),
      .rd_en   (accept),
      .rd_addr (pos.addr),
      .rd_data (rd_data)
   );

   // Gather the new window column and shift the stored rows up by one
   always_comb begin
      line_word = fwd_hit_ff ? fwd_data_ff : cbp_pkg::line_word_type'(rd_data);
      for (int k = 0; k < cbp_pkg::LINES; k++) begin
         column[k] = line_word[k];
      end
      column[cbp_pkg::LINES] = s1_pixel_ff;
      for (int k = 0; k < cbp_pkg::LINES - 1; k++) begin
         wr_word[k] = line_word[k + 1];
      end
      wr_word[cbp_pkg::LINES - 1] = s1_pixel_ff;
   end

   // Shift the window left and insert the new column on the right
   always_comb begin
      for (int dr = 0; dr < cbp_pkg::SPAN; dr++) begin
         for (int dc = 0; dc < cbp_pkg::SPAN - 1; dc++) begin
            win_next[dr * cbp_pkg::SPAN + dc] = window_ff[dr * cbp_pkg::SPAN + dc + 1];
         end
         win_next[dr * cbp_pkg::SPAN + cbp_pkg::SPAN - 1] = column[dr];
      end
   end

   // Compare each neighbor with the center, skipping the center itself
   always_comb begin
      center = win_next[cbp_pkg::CENTER];
      for (int i = 0; i < cbp_pkg::WIN_SIZE; i++) begin
         if (i < cbp_pkg::CENTER) begin
            neighbor_le[i] = (win_next[i] <= center);
         end else if (i > cbp_pkg::CENTER) begin
            neighbor_le[i - 1] = (win_next[i] <= center);
         end
      end
   end

   // Result register: load on advance, drop once taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = s1_pos_ff.emit;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < cbp_pkg::WIN_SIZE; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_hit_ff   <= fwd_hit_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            for (int i = 0; i < cbp_pkg::WIN_SIZE; i++) begin
               window_ff[i] <= win_next[i];
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pos_ff   <= pos;
         s1_pixel_ff <= cbp_pkg::PIXEL_BITS'(req_chan.pixel_value);
         fwd_data_ff <= wr_word;
      end
      if (advance && s1_pos_ff.emit) begin
         out_bits_ff <= neighbor_le[cbp_pkg::CENSUS_W-1:0];
         out_col_ff  <= s1_pos_ff.center_col;
         out_row_ff  <= s1_pos_ff.center_row;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.census_bits = out_bits_ff;
   assign rsp_chan.center_col  = out_col_ff;
   assign rsp_chan.center_row  = out_row_ff;

   // The bypass only applies to a request waiting in the input stage
   a_fwd_needs_stage: assert property (@(posedge clock) disable iff (reset)
      fwd_hit_ff |-> s1_valid_ff)
      else $error("bypass flag set with empty input stage");

   // A full stage behind a stalled result must block new requests
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request taken while pipeline stalled");

   // A window with a full neighborhood must show up as a result
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_pos_ff.emit) |=> out_valid_ff)
      else $error("census result lost");

endmodule
